[design/cpt_pkg.sv]
`timescale 1ns / 1ps
// shared constants and types for the closest point on triangle block
// no dependencies; used by the front, back and top level modules
package cpt_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH    = 4;

    typedef enum logic [2:0] {
        RG_VERT_A  = 3'd0,
        RG_VERT_B  = 3'd1,
        RG_EDGE_AB = 3'd2,
        RG_VERT_C  = 3'd3,
        RG_EDGE_AC = 3'd4,
        RG_EDGE_BC = 3'd5,
        RG_FACE    = 3'd6
    } t_region;

    // how many weighted direction terms are added to the base vertex
    typedef enum logic [1:0] {
        NT_NONE = 2'd0,
        NT_ONE  = 2'd1,
        NT_TWO  = 2'd2
    } t_nterm;

    typedef struct packed {
        t_region region;
        t_nterm  nterm;
        logic    degen;
    } t_ctl;

endpackage

[design/cpt_wmul.sv]
`timescale 1ns / 1ps
// two-stage signed multiplier built from four half-width partial products
// no dependencies; used by cpt_front for the cross terms of the dot products
module cpt_wmul #(
    parameter int W = 68,
    localparam int PW = 2 * W
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [W-1:0]  i_x,
    input  logic signed [W-1:0]  i_y,
    output logic signed [PW-1:0] o_p
);

    localparam int LW = W / 2;
    localparam int HW = W - LW;

    logic        [LW-1:0]    xl, yl;
    logic signed [HW-1:0]    xh, yh;
    logic        [2*LW-1:0]  r_ll;
    logic signed [HW+LW:0]   r_lh, r_hl;
    logic signed [2*HW-1:0]  r_hh;
    logic signed [PW-1:0]    r_p;

    assign xl = i_x[LW-1:0];
    assign yl = i_y[LW-1:0];
    assign xh = i_x[W-1:LW];
    assign yh = i_y[W-1:LW];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= xl * yl;
            r_lh <= xh * $signed({1'b0, yl});
            r_hl <= yh * $signed({1'b0, xl});
            r_hh <= xh * yh;
            r_p  <= (PW'(r_hh) <<< (2 * LW)) + (PW'(r_lh) <<< LW)
                  + (PW'(r_hl) <<< LW) + PW'(r_ll);
        end
    end

    assign o_p = r_p;

endmodule

[design/cpt_fifo.sv]
`timescale 1ns / 1ps
// short ready/valid queue between the classify front and the weighting back
// uses cpt_pkg for the default depth
module cpt_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = cpt_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW:0]      r_wp, r_rp;
    logic             full, empty;

    assign empty   = (r_wp == r_rp);
    assign full    = (r_wp[AW] != r_rp[AW]) && (r_wp[AW-1:0] == r_rp[AW-1:0]);
    assign o_ready = !full;
    assign o_valid = !empty;
    assign o_data  = r_mem[r_rp[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (i_valid && !full) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_ready && !empty) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !full) begin
            r_mem[r_wp[AW-1:0]] <= i_data;
        end
    end

endmodule

[design/cpt_front.sv]
`timescale 1ns / 1ps
// front part: edge vectors, dot products, cross terms and region classification
// uses cpt_pkg for region codes and cpt_wmul for the wide cross products
module cpt_front #(
    parameter int COORD_BITS = cpt_pkg::COORD_BITS_DEF,
    localparam int DW   = COORD_BITS + 1,
    localparam int DIVW = 4 * COORD_BITS + 11
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [2:0][COORD_BITS-1:0]   i_p,
    input  logic [2:0][COORD_BITS-1:0]   i_a,
    input  logic [2:0][COORD_BITS-1:0]   i_b,
    input  logic [2:0][COORD_BITS-1:0]   i_c,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [2:0][COORD_BITS-1:0]   o_base,
    output logic [2:0][DW-1:0]           o_dir1,
    output logic [2:0][DW-1:0]           o_dir2,
    output logic [DIVW-1:0]              o_num1,
    output logic [DIVW-1:0]              o_num2,
    output logic [DIVW-1:0]              o_den,
    output cpt_pkg::t_ctl                o_ctl
);

    localparam int PW   = 2 * DW;
    localparam int DOTW = PW + 2;
    localparam int EW   = DOTW + 1;
    localparam int VPW  = 2 * DOTW;
    localparam int VW   = VPW + 1;
    localparam int MA [6] = '{0, 2, 4, 0, 2, 4};
    localparam int MB [6] = '{3, 1, 1, 5, 5, 3};

    typedef struct packed {
        logic [2:0][COORD_BITS-1:0] a;
        logic [2:0][COORD_BITS-1:0] b;
        logic [2:0][COORD_BITS-1:0] c;
        logic [2:0][DW-1:0]         ab;
        logic [2:0][DW-1:0]         ac;
        logic [2:0][DW-1:0]         bc;
    } t_geo;

    logic                      en;
    logic [7:1]                r_v;
    t_geo                      n_geo;
    t_geo                      r_geo [1:6];
    logic [2:0][DW-1:0]        n_ap, n_bp, n_cp, r_ap, r_bp, r_cp;
    logic signed [PW-1:0]      n_m [6][3];
    logic signed [PW-1:0]      r_m [6][3];
    logic [5:0][DOTW-1:0]      n_d;
    logic [5:0][DOTW-1:0]      r_d [3:6];
    logic signed [VPW-1:0]     w_m [6];
    logic signed [VW-1:0]      r_va, r_vb, r_vc;

    t_geo                      g;
    logic signed [DOTW-1:0]    d1, d2, d3, d4, d5, d6;
    logic signed [EW-1:0]      e, f, den_ab, den_ac;
    logic [2:0][COORD_BITS-1:0] n_base, r_base;
    logic [2:0][DW-1:0]        n_dir1, n_dir2, r_dir1, r_dir2;
    logic [DIVW-1:0]           n_num1, n_num2, n_den, r_num1, r_num2, r_den;
    cpt_pkg::t_ctl             n_ctl, r_ctl;

    // stall only when the last stage holds an item the queue cannot take
    assign en      = !r_v[7] || i_ready;
    assign o_ready = en && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[6:1], i_valid};
        end
    end

    // stage 1: edge and offset vectors
    always_comb begin
        n_geo.a = i_a;
        n_geo.b = i_b;
        n_geo.c = i_c;
        for (int k = 0; k < 3; k++) begin
            n_geo.ab[k] = DW'($signed(i_b[k])) - DW'($signed(i_a[k]));
            n_geo.ac[k] = DW'($signed(i_c[k])) - DW'($signed(i_a[k]));
            n_geo.bc[k] = DW'($signed(i_c[k])) - DW'($signed(i_b[k]));
            n_ap[k]     = DW'($signed(i_p[k])) - DW'($signed(i_a[k]));
            n_bp[k]     = DW'($signed(i_p[k])) - DW'($signed(i_b[k]));
            n_cp[k]     = DW'($signed(i_p[k])) - DW'($signed(i_c[k]));
        end
    end

    // stage 2: component products of the six dot products
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_m[0][k] = $signed(r_geo[1].ab[k]) * $signed(r_ap[k]);
            n_m[1][k] = $signed(r_geo[1].ac[k]) * $signed(r_ap[k]);
            n_m[2][k] = $signed(r_geo[1].ab[k]) * $signed(r_bp[k]);
            n_m[3][k] = $signed(r_geo[1].ac[k]) * $signed(r_bp[k]);
            n_m[4][k] = $signed(r_geo[1].ab[k]) * $signed(r_cp[k]);
            n_m[5][k] = $signed(r_geo[1].ac[k]) * $signed(r_cp[k]);
        end
    end

    // stage 3: dot product sums d1..d6
    always_comb begin
        for (int j = 0; j < 6; j++) begin
            n_d[j] = DOTW'(r_m[j][0]) + DOTW'(r_m[j][1]) + DOTW'(r_m[j][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_geo[1] <= n_geo;
            r_ap     <= n_ap;
            r_bp     <= n_bp;
            r_cp     <= n_cp;
            for (int k = 2; k <= 6; k++) begin
                r_geo[k] <= r_geo[k-1];
            end
            r_m    <= n_m;
            r_d[3] <= n_d;
            for (int k = 4; k <= 6; k++) begin
                r_d[k] <= r_d[k-1];
            end
            r_vc <= VW'(w_m[0]) - VW'(w_m[1]);
            r_vb <= VW'(w_m[2]) - VW'(w_m[3]);
            r_va <= VW'(w_m[4]) - VW'(w_m[5]);
        end
    end

    // stages 4 and 5: cross terms d1*d4, d3*d2, d5*d2, d1*d6, d3*d6, d5*d4
    for (genvar gi = 0; gi < 6; gi++) begin : g_cross
        cpt_wmul #(
            .W (DOTW)
        ) u_mul (
            .i_clk (i_clk),
            .i_en  (en),
            .i_x   (r_d[3][MA[gi]]),
            .i_y   (r_d[3][MB[gi]]),
            .o_p   (w_m[gi])
        );
    end

    // stage 7: region tests in priority order a, b, ab, c, ac, bc, face
    always_comb begin
        g      = r_geo[6];
        d1     = $signed(r_d[6][0]);
        d2     = $signed(r_d[6][1]);
        d3     = $signed(r_d[6][2]);
        d4     = $signed(r_d[6][3]);
        d5     = $signed(r_d[6][4]);
        d6     = $signed(r_d[6][5]);
        e      = EW'(d4) - EW'(d3);
        f      = EW'(d5) - EW'(d6);
        den_ab = EW'(d1) - EW'(d3);
        den_ac = EW'(d2) - EW'(d6);

        n_base       = g.a;
        n_dir1       = g.ab;
        n_dir2       = g.ac;
        n_num1       = DIVW'(r_vb);
        n_num2       = DIVW'(r_vc);
        n_den        = DIVW'(r_va) + DIVW'(r_vb) + DIVW'(r_vc);
        n_ctl.region = cpt_pkg::RG_FACE;
        n_ctl.nterm  = cpt_pkg::NT_TWO;
        n_ctl.degen  = 1'b0;

        if (d1 <= 0 && d2 <= 0) begin
            n_ctl.region = cpt_pkg::RG_VERT_A;
            n_ctl.nterm  = cpt_pkg::NT_NONE;
        end else if (d3 >= 0 && d4 <= d3) begin
            n_ctl.region = cpt_pkg::RG_VERT_B;
            n_ctl.nterm  = cpt_pkg::NT_NONE;
            n_base       = g.b;
        end else if (r_vc <= 0 && d1 >= 0 && d3 <= 0) begin
            n_ctl.region = cpt_pkg::RG_EDGE_AB;
            n_ctl.nterm  = cpt_pkg::NT_ONE;
            n_num1       = DIVW'(d1);
            n_den        = DIVW'(den_ab);
        end else if (d6 >= 0 && d5 <= d6) begin
            n_ctl.region = cpt_pkg::RG_VERT_C;
            n_ctl.nterm  = cpt_pkg::NT_NONE;
            n_base       = g.c;
        end else if (r_vb <= 0 && d2 >= 0 && d6 <= 0) begin
            n_ctl.region = cpt_pkg::RG_EDGE_AC;
            n_ctl.nterm  = cpt_pkg::NT_ONE;
            n_dir1       = g.ac;
            n_num1       = DIVW'(d2);
            n_den        = DIVW'(den_ac);
        end else if (r_va <= 0 && e >= 0 && f >= 0) begin
            n_ctl.region = cpt_pkg::RG_EDGE_BC;
            n_ctl.nterm  = cpt_pkg::NT_ONE;
            n_base       = g.b;
            n_dir1       = g.bc;
            n_num1       = DIVW'(e);
            n_den        = DIVW'(e) + DIVW'(f);
        end

        // zero denominator falls back to vertex a
        if (n_ctl.nterm != cpt_pkg::NT_NONE && n_den == '0) begin
            n_ctl.degen = 1'b1;
            n_ctl.nterm = cpt_pkg::NT_NONE;
            n_base      = g.a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_base <= n_base;
            r_dir1 <= n_dir1;
            r_dir2 <= n_dir2;
            r_num1 <= n_num1;
            r_num2 <= n_num2;
            r_den  <= n_den;
            r_ctl  <= n_ctl;
        end
    end

    assign o_valid = r_v[7];
    assign o_base  = r_base;
    assign o_dir1  = r_dir1;
    assign o_dir2  = r_dir2;
    assign o_num1  = r_num1;
    assign o_num2  = r_num2;
    assign o_den   = r_den;
    assign o_ctl   = r_ctl;

endmodule

[design/cpt_back.sv]
`timescale 1ns / 1ps
// back part: pipelined restoring division for the weights, weighted sum, saturation
// uses cpt_pkg for the term count and control struct
module cpt_back #(
    parameter int COORD_BITS = cpt_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = cpt_pkg::FRAC_BITS_DEF,
    localparam int DW   = COORD_BITS + 1,
    localparam int DIVW = 4 * COORD_BITS + 11
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [2:0][COORD_BITS-1:0] i_base,
    input  logic [2:0][DW-1:0]         i_dir1,
    input  logic [2:0][DW-1:0]         i_dir2,
    input  logic [DIVW-1:0]            i_num1,
    input  logic [DIVW-1:0]            i_num2,
    input  logic [DIVW-1:0]            i_den,
    input  cpt_pkg::t_ctl              i_ctl,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [2:0][COORD_BITS-1:0] o_near,
    output logic [2:0]                 o_region,
    output logic                       o_degen
);

    localparam int WW = FRAC_BITS + 1;
    localparam int TW = DW + WW + 1;
    localparam int SW = COORD_BITS + 5;
    localparam int NS = FRAC_BITS;
    localparam logic signed [SW-1:0] SAT_HI =
        $signed(SW'({1'b0, {(COORD_BITS-1){1'b1}}}));
    localparam logic signed [SW-1:0] SAT_LO =
        $signed({{(SW-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}});

    typedef struct packed {
        logic [2:0][COORD_BITS-1:0] base;
        logic [2:0][DW-1:0]         dir1;
        logic [2:0][DW-1:0]         dir2;
        cpt_pkg::t_ctl              ctl;
    } t_job;

    logic                  en;
    logic [NS+1:0]         r_bv;
    t_job                  r_job [0:NS+1];
    logic [DIVW-1:0]       r_den [0:NS];
    logic [DIVW-1:0]       r_rem [0:NS][2];
    logic [FRAC_BITS-1:0]  r_quo [0:NS][2];
    logic                  r_neg [0:NS][2];
    logic                  r_big [0:NS][2];

    logic [DIVW-1:0]       n_ad;
    logic [DIVW-1:0]       n_rem0 [2];
    logic                  n_neg0 [2];
    logic                  n_big0 [2];
    logic [DIVW-1:0]       n_rem [1:NS][2];
    logic [FRAC_BITS-1:0]  n_quo [1:NS][2];

    logic [WW-1:0]         w [2];
    logic signed [TW-1:0]  r_t1 [3], r_t2 [3];
    logic signed [SW-1:0]  s [3];
    logic [2:0][COORD_BITS-1:0] n_near, r_near;
    logic                  r_ov;
    logic [2:0]            r_region;
    logic                  r_degen;

    assign en      = !r_ov || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= '0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_bv <= {r_bv[NS:0], i_valid};
            r_ov <= r_bv[NS+1];
        end
    end

    // stage 0: signs and magnitudes; a ratio of one or more clamps straight away
    always_comb begin
        logic [DIVW-1:0] num;
        logic [DIVW-1:0] an;
        n_ad = i_den[DIVW-1] ? -i_den : i_den;
        for (int j = 0; j < 2; j++) begin
            num       = (j == 0) ? i_num1 : i_num2;
            an        = num[DIVW-1] ? -num : num;
            n_neg0[j] = num[DIVW-1] ^ i_den[DIVW-1];
            n_big0[j] = (an >= n_ad);
            n_rem0[j] = n_big0[j] ? '0 : an;
        end
    end

    // one quotient bit per stage, remainder stays below the divisor
    always_comb begin
        logic [DIVW:0] t2;
        for (int k = 1; k <= NS; k++) begin
            for (int j = 0; j < 2; j++) begin
                t2 = {r_rem[k-1][j], 1'b0};
                if (t2 >= {1'b0, r_den[k-1]}) begin
                    n_rem[k][j] = DIVW'(t2 - {1'b0, r_den[k-1]});
                    n_quo[k][j] = {r_quo[k-1][j][FRAC_BITS-2:0], 1'b1};
                end else begin
                    n_rem[k][j] = t2[DIVW-1:0];
                    n_quo[k][j] = {r_quo[k-1][j][FRAC_BITS-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_job[0] <= '{base: i_base, dir1: i_dir1, dir2: i_dir2, ctl: i_ctl};
            r_den[0] <= n_ad;
            for (int j = 0; j < 2; j++) begin
                r_rem[0][j] <= n_rem0[j];
                r_quo[0][j] <= '0;
                r_neg[0][j] <= n_neg0[j];
                r_big[0][j] <= n_big0[j];
            end
            for (int k = 1; k <= NS; k++) begin
                r_den[k] <= r_den[k-1];
                for (int j = 0; j < 2; j++) begin
                    r_rem[k][j] <= n_rem[k][j];
                    r_quo[k][j] <= n_quo[k][j];
                    r_neg[k][j] <= r_neg[k-1][j];
                    r_big[k][j] <= r_big[k-1][j];
                end
            end
            for (int k = 1; k <= NS + 1; k++) begin
                r_job[k] <= r_job[k-1];
            end
        end
    end

    // weights clamped to [0, one], then direction times weight
    always_comb begin
        for (int j = 0; j < 2; j++) begin
            if (r_neg[NS][j]) begin
                w[j] = '0;
            end else if (r_big[NS][j]) begin
                w[j] = {1'b1, {FRAC_BITS{1'b0}}};
            end else begin
                w[j] = {1'b0, r_quo[NS][j]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_t1[k] <= $signed(r_job[NS].dir1[k]) * $signed({1'b0, w[0]});
                r_t2[k] <= $signed(r_job[NS].dir2[k]) * $signed({1'b0, w[1]});
            end
        end
    end

    // floor-shifted terms added to the base, then saturated
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            s[k] = SW'($signed(r_job[NS+1].base[k]));
            if (r_job[NS+1].ctl.nterm != cpt_pkg::NT_NONE) begin
                s[k] = s[k] + SW'(r_t1[k] >>> FRAC_BITS);
            end
            if (r_job[NS+1].ctl.nterm == cpt_pkg::NT_TWO) begin
                s[k] = s[k] + SW'(r_t2[k] >>> FRAC_BITS);
            end
            if (s[k] > SAT_HI) begin
                n_near[k] = SAT_HI[COORD_BITS-1:0];
            end else if (s[k] < SAT_LO) begin
                n_near[k] = SAT_LO[COORD_BITS-1:0];
            end else begin
                n_near[k] = s[k][COORD_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_near   <= n_near;
            r_region <= r_job[NS+1].ctl.region;
            r_degen  <= r_job[NS+1].ctl.degen;
        end
    end

    assign o_valid  = r_ov;
    assign o_near   = r_near;
    assign o_region = r_region;
    assign o_degen  = r_degen;

endmodule

[design/closest_point_on_triangle.sv]
`timescale 1ns / 1ps
// throughput: one item per cycle unless m_axis_tready stalls the output; 7 front
// stages, a 4-entry queue, then one division stage per weight fraction bit plus multiply and output stages
// reset: synchronous active-low i_rst_n clears stage valid flags and queue pointers
// depends on cpt_pkg, cpt_front, cpt_fifo, cpt_back
module closest_point_on_triangle #(
    parameter int COORD_BITS = cpt_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = cpt_pkg::FRAC_BITS_DEF,
    localparam int IN_W  = ((12 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((3 * COORD_BITS + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // query_x, query_y, query_z, vert_a_x/y/z, vert_b_x/y/z, vert_c_x/y/z
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // nearest_x, nearest_y, nearest_z
    output logic [OUT_W-1:0] m_axis_tdata,
    // region [2:0], degenerate [3]
    output logic [3:0]       m_axis_tuser
);

    localparam int DW   = COORD_BITS + 1;
    localparam int DIVW = 4 * COORD_BITS + 11;
    localparam int QW   = 3 * COORD_BITS + 6 * DW + 3 * DIVW + $bits(cpt_pkg::t_ctl);

    logic [2:0][COORD_BITS-1:0] p, a, b, c;
    logic                       f_valid, f_ready;
    logic [2:0][COORD_BITS-1:0] f_base, q_base;
    logic [2:0][DW-1:0]         f_dir1, f_dir2, q_dir1, q_dir2;
    logic [DIVW-1:0]            f_num1, f_num2, f_den, q_num1, q_num2, q_den;
    cpt_pkg::t_ctl              f_ctl, q_ctl;
    logic [QW-1:0]              f_data, q_data;
    logic                       q_valid, q_ready;
    logic [2:0][COORD_BITS-1:0] near;
    logic [2:0]                 region;
    logic                       degen;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            p[k] = s_axis_tdata[k*COORD_BITS +: COORD_BITS];
            a[k] = s_axis_tdata[(3+k)*COORD_BITS +: COORD_BITS];
            b[k] = s_axis_tdata[(6+k)*COORD_BITS +: COORD_BITS];
            c[k] = s_axis_tdata[(9+k)*COORD_BITS +: COORD_BITS];
        end
    end

    cpt_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_p     (p),
        .i_a     (a),
        .i_b     (b),
        .i_c     (c),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_base  (f_base),
        .o_dir1  (f_dir1),
        .o_dir2  (f_dir2),
        .o_num1  (f_num1),
        .o_num2  (f_num2),
        .o_den   (f_den),
        .o_ctl   (f_ctl)
    );

    assign f_data = {f_base, f_dir1, f_dir2, f_num1, f_num2, f_den, f_ctl};

    cpt_fifo #(
        .WIDTH (QW),
        .DEPTH (cpt_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  (f_data),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_data)
    );

    assign {q_base, q_dir1, q_dir2, q_num1, q_num2, q_den, q_ctl} = q_data;

    cpt_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .o_ready  (q_ready),
        .i_base   (q_base),
        .i_dir1   (q_dir1),
        .i_dir2   (q_dir2),
        .i_num1   (q_num1),
        .i_num2   (q_num2),
        .i_den    (q_den),
        .i_ctl    (q_ctl),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_near   (near),
        .o_region (region),
        .o_degen  (degen)
    );

    assign m_axis_tdata = OUT_W'(near);
    assign m_axis_tuser = {degen, region};

endmodule
